// File: hw/rtl/mmq_pkg.sv
// Package for the MIDI message queue: queue sizing, request, kind and status codes,
// controller/datapath command and status structs, ring index helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmq_pkg;

	localparam int QUEUE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int MAX_READ    = 64;
	localparam int CNT_W       = 7;
	localparam int CMP_W       = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	localparam logic [IDX_W:0] DEPTH_W   = (IDX_W + 1)'(QUEUE_DEPTH);
	localparam logic [IDX_W:0] LAST_SLOT = (IDX_W + 1)'(QUEUE_DEPTH - 1);

	localparam logic CFG_QUEUE_ENABLED = 1'b0;
	localparam logic CFG_DSP_RUNNING   = 1'b1;

	typedef enum logic [1:0] {
		REQ_MSG  = 2'd0,
		REQ_RAW  = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		KIND_NOTEON    = 3'd0,
		KIND_NOTEOFF   = 3'd1,
		KIND_CTLCHG    = 3'd2,
		KIND_PGMCHG    = 3'd3,
		KIND_POLYTOUCH = 3'd4,
		KIND_TOUCH     = 3'd5,
		KIND_BEND      = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DISABLED = 3'd1,
		ST_DSP_OFF  = 3'd2,
		ST_CHANNEL  = 3'd3,
		ST_DATA     = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef struct packed {
		logic load_in;
		logic msg_eval;
		logic msg_write;
		logic raw_step;
		logic rd_start;
		logic rd_emit;
		logic post;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		status_t    msg_err;
		logic       msg_last;
		logic       rd_none;
		logic       rd_last;
		logic       out_free;
	} stat_t;

	function automatic logic [IDX_W-1:0] idx_adv(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// bytes between head and tail, modulo the queue depth
	function automatic logic [IDX_W-1:0] idx_used(input logic [IDX_W-1:0] tail,
		input logic [IDX_W-1:0] head);
		logic [IDX_W:0] wrapped;
		wrapped = {1'b0, tail} + DEPTH_W - {1'b0, head};
		return (tail >= head) ? tail - head : wrapped[IDX_W-1:0];
	endfunction

	function automatic logic [7:0] kind_head(input logic [2:0] kind);
		logic [7:0] h;
		unique case (kind)
			KIND_NOTEON:    h = 8'h90;
			KIND_NOTEOFF:   h = 8'h80;
			KIND_CTLCHG:    h = 8'hb0;
			KIND_PGMCHG:    h = 8'hc0;
			KIND_POLYTOUCH: h = 8'ha0;
			KIND_TOUCH:     h = 8'hd0;
			KIND_BEND:      h = 8'he0;
			default:        h = 8'h00;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmq_ctrl.sv
// Controller of the MIDI message queue: sequences each accepted word through
// evaluation, store writes, drains and result posting. Depends on mmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmq_ctrl
	import mmq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MSG_WR,
		S_RD_EMIT,
		S_POST
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd = '0;
		cmd.load_in = in_valid && in_ready_q;
		unique case (state_q)
			S_EXEC: begin
				case (stat.req)
					REQ_MSG:  cmd.msg_eval = 1'b1;
					REQ_RAW:  cmd.raw_step = 1'b1;
					REQ_READ: cmd.rd_start = 1'b1;
					default:  ;
				endcase
			end
			S_MSG_WR:  cmd.msg_write = 1'b1;
			S_RD_EMIT: cmd.rd_emit = stat.out_free;
			S_POST:    cmd.post = stat.out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					case (stat.req)
						REQ_MSG:  state_q <= (stat.msg_err == ST_OK) ? S_MSG_WR : S_POST;
						REQ_RAW:  state_q <= S_POST;
						REQ_READ: state_q <= stat.rd_none ? S_POST : S_RD_EMIT;
						default: begin
							state_q    <= S_IDLE;
							in_ready_q <= 1'b1;
						end
					endcase
				end
				S_MSG_WR: begin
					if (stat.msg_last) begin
						state_q <= S_POST;
					end
				end
				S_RD_EMIT: begin
					if (stat.out_free && stat.rd_last) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_POST: begin
					if (stat.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.msg_write || cmd.rd_emit || cmd.post || cmd.raw_step) |-> !in_ready_q)
		else $error("work command issued while taking new words");

	a_drain_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_EMIT && stat.out_free && stat.rd_last) |=> in_ready_q)
		else $error("final drained byte did not return controller to idle");

endmodule

`default_nettype wire

// File: hw/rtl/mmq_datapath.sv
// Datapath of the MIDI message queue: configuration registers, ring indices,
// byte store, message encoder and checks, output register. Depends on mmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmq_datapath
	import mmq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  req_type,
	input  wire logic [2:0]  msg_kind,
	input  wire logic [4:0]  channel,
	input  wire logic [7:0]  first_data,
	input  wire logic [7:0]  second_data,
	input  wire logic [14:0] bend_value,
	input  wire logic        last_of_message,
	input  wire logic [6:0]  read_limit,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last,
	output logic [2:0]       status,
	input  wire cmd_t        cmd,
	output stat_t            stat
);

	// latched word
	logic [1:0]  req_type_q;
	logic [2:0]  msg_kind_q;
	logic [4:0]  channel_q;
	logic [7:0]  first_data_q;
	logic [7:0]  second_data_q;
	logic [14:0] bend_value_q;
	logic        last_of_message_q;
	logic [6:0]  read_limit_q;

	logic             queue_enabled_q;
	logic             dsp_running_q;
	logic [IDX_W-1:0] write_index_q;
	logic [IDX_W-1:0] read_index_q;
	logic [IDX_W-1:0] pending_index_q;
	status_t          pending_error_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       byte_sel_q;

	logic [7:0] mem_q [QUEUE_DEPTH];
	logic [7:0] rdata_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             byte_valid_q;
	logic             last_q;
	status_t          out_status_q;

	logic             queue_clear;
	logic [1:0]       msg_len;
	logic [7:0]       msg_byte;
	status_t          msg_err;
	logic [IDX_W-1:0] used_wr;
	logic [IDX_W-1:0] used_pend;
	status_t          raw_check;
	status_t          raw_err;
	logic             raw_wr;
	logic [IDX_W-1:0] pend_adv;
	logic [CNT_W-1:0] rd_lim;
	logic [IDX_W-1:0] rd_avail;
	logic [CNT_W-1:0] rd_n;
	logic             out_free;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic [IDX_W-1:0] rd_addr;

	assign queue_clear = cfg_we && (cfg_index == CFG_QUEUE_ENABLED) && cfg_data
		&& !queue_enabled_q;
	assign out_free = !out_valid_q || out_ready;

	// channel message encoding and checks, in priority order
	assign msg_len = (msg_kind_q == KIND_PGMCHG || msg_kind_q == KIND_TOUCH) ? 2'd2 : 2'd3;
	assign used_wr = idx_used(write_index_q, read_index_q);

	always_comb begin
		unique case (byte_sel_q)
			2'd0:    msg_byte = kind_head(msg_kind_q) | {4'h0, 4'(channel_q - 5'd1)};
			2'd1:    msg_byte = (msg_kind_q == KIND_BEND) ? {1'b0, bend_value_q[6:0]}
				: first_data_q;
			2'd2:    msg_byte = (msg_kind_q == KIND_BEND) ? bend_value_q[14:7] : second_data_q;
			default: msg_byte = 8'h00;
		endcase
	end

	always_comb begin
		priority if (!queue_enabled_q) begin
			msg_err = ST_DISABLED;
		end else if (!dsp_running_q) begin
			msg_err = ST_DSP_OFF;
		end else if (channel_q == 5'd0 || channel_q > 5'd16) begin
			msg_err = ST_CHANNEL;
		end else if (msg_kind_q == 3'd7) begin
			msg_err = ST_DATA;
		end else if (msg_kind_q == KIND_BEND && bend_value_q[14]) begin
			msg_err = ST_DATA;
		end else if ((msg_kind_q == KIND_PGMCHG || msg_kind_q == KIND_TOUCH)
			&& first_data_q[7]) begin
			msg_err = ST_DATA;
		end else if (msg_kind_q != KIND_BEND && msg_kind_q != KIND_PGMCHG
			&& msg_kind_q != KIND_TOUCH && (first_data_q[7] || second_data_q[7])) begin
			msg_err = ST_DATA;
		end else if (pending_index_q != write_index_q || pending_error_q != ST_OK) begin
			msg_err = ST_FULL;
		end else if (({1'b0, used_wr} + (IDX_W + 1)'(msg_len)) > LAST_SLOT) begin
			msg_err = ST_FULL;
		end else begin
			msg_err = ST_OK;
		end
	end

	// raw byte list
	assign used_pend = idx_used(pending_index_q, read_index_q);

	always_comb begin
		priority if (!queue_enabled_q) begin
			raw_check = ST_DISABLED;
		end else if (!dsp_running_q) begin
			raw_check = ST_DSP_OFF;
		end else if ({1'b0, used_pend} == LAST_SLOT) begin
			raw_check = ST_FULL;
		end else begin
			raw_check = ST_OK;
		end
	end

	assign raw_err  = (pending_error_q != ST_OK) ? pending_error_q : raw_check;
	assign raw_wr   = cmd.raw_step && pending_error_q == ST_OK && raw_check == ST_OK;
	assign pend_adv = raw_wr ? idx_adv(pending_index_q) : pending_index_q;

	// drain length: committed bytes, capped by the request limit, itself capped at MAX_READ
	assign rd_lim   = (read_limit_q > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : read_limit_q;
	assign rd_avail = used_wr;
	assign rd_n     = (CMP_W'(rd_avail) < CMP_W'(rd_lim)) ? CNT_W'(rd_avail) : rd_lim;

	// store ports
	assign wr_en   = cmd.msg_write || raw_wr;
	assign wr_addr = cmd.msg_write ? write_index_q : pending_index_q;
	assign wr_data = cmd.msg_write ? msg_byte : first_data_q;
	assign rd_addr = cmd.rd_emit ? idx_adv(read_index_q) : read_index_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_type_q        <= req_type;
			msg_kind_q        <= msg_kind;
			channel_q         <= channel;
			first_data_q      <= first_data;
			second_data_q     <= second_data;
			bend_value_q      <= bend_value;
			last_of_message_q <= last_of_message;
			read_limit_q      <= read_limit;
		end
		if (cmd.msg_eval) begin
			status_q <= msg_err;
		end else if (cmd.raw_step) begin
			status_q <= raw_err;
		end else if (cmd.rd_start) begin
			status_q <= queue_enabled_q ? ST_OK : ST_DISABLED;
		end
		if (cmd.rd_emit) begin
			out_byte_q   <= rdata_q;
			byte_valid_q <= 1'b1;
			last_q       <= (count_q == CNT_W'(1));
			out_status_q <= ST_OK;
		end else if (cmd.post) begin
			out_byte_q   <= 8'h00;
			byte_valid_q <= 1'b0;
			last_q       <= 1'b1;
			out_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_enabled_q <= 1'b0;
			dsp_running_q   <= 1'b0;
			write_index_q   <= '0;
			read_index_q    <= '0;
			pending_index_q <= '0;
			pending_error_q <= ST_OK;
			count_q         <= '0;
			byte_sel_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_QUEUE_ENABLED) begin
				queue_enabled_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_DSP_RUNNING) begin
				dsp_running_q <= cfg_data;
			end

			if (queue_clear) begin
				write_index_q   <= '0;
				read_index_q    <= '0;
				pending_index_q <= '0;
				pending_error_q <= ST_OK;
			end else if (cmd.msg_write) begin
				write_index_q   <= idx_adv(write_index_q);
				pending_index_q <= idx_adv(write_index_q);
			end else if (cmd.raw_step) begin
				if (last_of_message_q) begin
					// commit or drop the open list
					if (raw_err == ST_OK) begin
						write_index_q   <= pend_adv;
						pending_index_q <= pend_adv;
					end else begin
						pending_index_q <= write_index_q;
					end
					pending_error_q <= ST_OK;
				end else begin
					pending_index_q <= pend_adv;
					pending_error_q <= raw_err;
				end
			end else if (cmd.rd_emit) begin
				read_index_q <= idx_adv(read_index_q);
			end

			if (cmd.rd_start) begin
				count_q <= rd_n;
			end else if (cmd.rd_emit) begin
				count_q <= count_q - 1'b1;
			end

			if (cmd.msg_eval) begin
				byte_sel_q <= '0;
			end else if (cmd.msg_write) begin
				byte_sel_q <= byte_sel_q + 1'b1;
			end

			if (cmd.rd_emit || cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;
	assign status     = out_status_q;

	assign stat.req      = req_type_q;
	assign stat.msg_err  = msg_err;
	assign stat.msg_last = (byte_sel_q == msg_len - 2'd1);
	assign stat.rd_none  = !queue_enabled_q || rd_n == '0;
	assign stat.rd_last  = (count_q == CNT_W'(1));
	assign stat.out_free = out_free;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_emit || cmd.post) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_msg_closes_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.msg_write |=> (pending_index_q == write_index_q))
		else $error("pending index left apart from write index after a message");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, write_index_q} < DEPTH_W) && ({1'b0, read_index_q} < DEPTH_W)
		&& ({1'b0, pending_index_q} < DEPTH_W))
		else $error("ring index beyond queue depth");

endmodule

`default_nettype wire

// File: hw/rtl/midi_message_queue.sv
// midi_message_queue top level: mmq_ctrl sequences mmq_datapath; uses mmq_pkg.
// Sequence: a channel message is accepted, checked, then (when stored) written with one store
// write per byte, and its result posted; a raw byte is accepted, stored and posted; a read drains
// its bytes one per cycle while the output register is free. One word at a time: a new word is
// taken only once the previous one has finished.
// Reset: indices, pending error, registers and handshake clear at once; store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module midi_message_queue
	import mmq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [2:0]  msg_kind,
	input  wire logic [4:0]  channel,
	input  wire logic [7:0]  first_data,
	input  wire logic [7:0]  second_data,
	input  wire logic [14:0] bend_value,
	input  wire logic        last_of_message,
	input  wire logic [6:0]  read_limit,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last,
	output logic [2:0]       status,
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data
);

	// commands downward, status upward: the only link between the two halves
	cmd_t  cmd;
	stat_t stat;

	// Controller: take a word, evaluate it, then step through store writes
	// or drain bytes one per cycle while the output register is free; hold the
	// final result until the output register frees.
	mmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Datapath: latch the word, encode and check messages, keep the ring
	// indices and byte store, drive the output register. The output register
	// parts the two channels, so a new word is taken while a result waits.
	mmq_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_type        (req_type),
		.msg_kind        (msg_kind),
		.channel         (channel),
		.first_data      (first_data),
		.second_data     (second_data),
		.bend_value      (bend_value),
		.last_of_message (last_of_message),
		.read_limit      (read_limit),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_byte        (out_byte),
		.byte_valid      (byte_valid),
		.last            (last),
		.status          (status),
		.cmd             (cmd),
		.stat            (stat)
	);

endmodule

`default_nettype wire

// File: test/midi_message_queue_tb.sv
// Self-checking testbench for midi_message_queue: directed and random requests with
// randomised handshakes on both channels, results checked against an in-bench model.
// Depends on mmq_pkg and the midi_message_queue RTL only.
`timescale 1ns / 1ps

import mmq_pkg::*;

typedef struct packed {
	logic [1:0]  req;
	logic [2:0]  kind;
	logic [4:0]  chan;
	logic [7:0]  d1;
	logic [7:0]  d2;
	logic [14:0] bend;
	logic        fin;
	logic [6:0]  limit;
} midi_request_t;

typedef struct packed {
	logic [7:0] data;
	logic       data_valid;
	logic       final_word;
	logic [2:0] code;
} queue_word_t;

// Mirrors the queue state and holds the words the block still owes us.
class midi_queue_scoreboard;
	logic [7:0]       byte_store [QUEUE_DEPTH];
	logic [IDX_W-1:0] commit_tail;
	logic [IDX_W-1:0] drain_head;
	logic [IDX_W-1:0] list_tail;
	logic [2:0]       list_error;
	logic             queue_open;
	logic             dsp_on;
	queue_word_t      expected_words [$];
	int unsigned      failures;

	function new();
		foreach (byte_store[i]) byte_store[i] = 8'h00;
		commit_tail = '0;
		drain_head  = '0;
		list_tail   = '0;
		list_error  = ST_OK;
		queue_open  = 1'b0;
		dsp_on      = 1'b0;
		failures    = 0;
	endfunction

	function int used_after(logic [IDX_W-1:0] tail);
		return (int'(tail) + QUEUE_DEPTH - int'(drain_head)) % QUEUE_DEPTH;
	endfunction

	function int queued_bytes();
		return used_after(commit_tail);
	endfunction

	function int free_space();
		return QUEUE_DEPTH - 1 - used_after(commit_tail);
	endfunction

	function int pending_words();
		return expected_words.size();
	endfunction

	function logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] i);
		return (int'(i) == QUEUE_DEPTH - 1) ? '0 : i + 1'b1;
	endfunction

	function void add_expected(logic [7:0] data, logic data_valid, logic final_word,
		logic [2:0] code);
		queue_word_t w;
		w.data       = data;
		w.data_valid = data_valid;
		w.final_word = final_word;
		w.code       = code;
		expected_words.push_back(w);
	endfunction

	function void write_register(logic index, logic value);
		if (index == CFG_QUEUE_ENABLED) begin
			// opening the input empties the queue and drops any open list
			if (value && !queue_open) begin
				commit_tail = '0;
				drain_head  = '0;
				list_tail   = '0;
				list_error  = ST_OK;
			end
			queue_open = value;
		end else begin
			dsp_on = value;
		end
	endfunction

	function logic [2:0] store_message(midi_request_t r);
		logic [7:0] msg [3];
		int         count;
		if (!queue_open) return ST_DISABLED;
		if (!dsp_on) return ST_DSP_OFF;
		if (r.chan < 5'd1 || r.chan > 5'd16) return ST_CHANNEL;
		case (r.kind)
			KIND_NOTEON:    msg[0] = 8'h90;
			KIND_NOTEOFF:   msg[0] = 8'h80;
			KIND_CTLCHG:    msg[0] = 8'hb0;
			KIND_PGMCHG:    msg[0] = 8'hc0;
			KIND_POLYTOUCH: msg[0] = 8'ha0;
			KIND_TOUCH:     msg[0] = 8'hd0;
			KIND_BEND:      msg[0] = 8'he0;
			default:        return ST_DATA;
		endcase
		msg[0][3:0] = 4'(r.chan - 5'd1);
		if (r.kind == KIND_BEND) begin
			if (r.bend[14]) return ST_DATA;
			msg[1] = {1'b0, r.bend[6:0]};
			msg[2] = r.bend[14:7];
			count  = 3;
		end else if (r.kind == KIND_PGMCHG || r.kind == KIND_TOUCH) begin
			if (r.d1[7]) return ST_DATA;
			msg[1] = r.d1;
			count  = 2;
		end else begin
			if (r.d1[7] || r.d2[7]) return ST_DATA;
			msg[1] = r.d1;
			msg[2] = r.d2;
			count  = 3;
		end
		if (list_tail != commit_tail || list_error != ST_OK) return ST_FULL;
		if (free_space() < count) return ST_FULL;
		for (int i = 0; i < count; i++) begin
			byte_store[commit_tail] = msg[i];
			commit_tail = next_slot(commit_tail);
		end
		list_tail = commit_tail;
		return ST_OK;
	endfunction

	function logic [2:0] store_raw(midi_request_t r);
		logic [2:0] code;
		if (list_error == ST_OK) begin
			if (!queue_open) list_error = ST_DISABLED;
			else if (!dsp_on) list_error = ST_DSP_OFF;
			else if (used_after(list_tail) == QUEUE_DEPTH - 1) list_error = ST_FULL;
			else begin
				byte_store[list_tail] = r.d1;
				list_tail = next_slot(list_tail);
			end
		end
		code = list_error;
		if (r.fin) begin
			if (list_error == ST_OK) commit_tail = list_tail;
			list_tail  = commit_tail;
			list_error = ST_OK;
		end
		return code;
	endfunction

	function void take_request(midi_request_t r);
		int allowance;
		int count;
		if (r.req == REQ_MSG) begin
			add_expected(8'h00, 1'b0, 1'b1, store_message(r));
		end else if (r.req == REQ_RAW) begin
			add_expected(8'h00, 1'b0, 1'b1, store_raw(r));
		end else if (r.req == REQ_READ) begin
			if (!queue_open) begin
				add_expected(8'h00, 1'b0, 1'b1, ST_DISABLED);
				return;
			end
			allowance = (r.limit > 7'(MAX_READ)) ? MAX_READ : int'(r.limit);
			count = (queued_bytes() < allowance) ? queued_bytes() : allowance;
			if (count == 0) add_expected(8'h00, 1'b0, 1'b1, ST_OK);
			for (int k = 0; k < count; k++) begin
				add_expected(byte_store[drain_head], 1'b1, k == count - 1, ST_OK);
				drain_head = next_slot(drain_head);
			end
		end
	endfunction

	function void check_word(queue_word_t got);
		queue_word_t want;
		if (expected_words.size() == 0) begin
			$error("unexpected word: out_byte %02h byte_valid %0b last %0b status %0d",
				got.data, got.data_valid, got.final_word, got.code);
			failures++;
			return;
		end
		want = expected_words.pop_front();
		if (got.data !== want.data) begin
			$error("out_byte: expected %02h, got %02h", want.data, got.data);
			failures++;
		end
		if (got.data_valid !== want.data_valid) begin
			$error("byte_valid: expected %0b, got %0b", want.data_valid, got.data_valid);
			failures++;
		end
		if (got.final_word !== want.final_word) begin
			$error("last: expected %0b, got %0b", want.final_word, got.final_word);
			failures++;
		end
		if (got.code !== want.code) begin
			$error("status: expected %0d, got %0d", want.code, got.code);
			failures++;
		end
	endfunction
endclass

module midi_message_queue_tb;

	localparam int         LIMIT_CYCLES = 400000;
	localparam int         QUIET_CYCLES = 12;
	localparam int         HOLD_CYCLES  = 300;
	localparam logic [1:0] REQ_UNUSED   = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [2:0]  msg_kind;
	logic [4:0]  channel;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [14:0] bend_value;
	logic        last_of_message;
	logic [6:0]  read_limit;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic [2:0]  status;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;

	// idling switches for each side, and a one-shot request for a long receive stall
	bit          sender_idles   = 1'b1;
	bit          receiver_idles = 1'b1;
	bit          hold_requested = 1'b0;
	int unsigned cycle_count;

	midi_queue_scoreboard sb = new();

	midi_message_queue dut (.*);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---- request builders; fields the request type ignores are filled at random ----

	function automatic midi_request_t channel_message(logic [2:0] kind, logic [4:0] chan,
		logic [7:0] d1, logic [7:0] d2, logic [14:0] bend);
		midi_request_t r;
		r.req   = REQ_MSG;
		r.kind  = kind;
		r.chan  = chan;
		r.d1    = d1;
		r.d2    = d2;
		r.bend  = bend;
		r.fin   = 1'($urandom);
		r.limit = 7'($urandom);
		return r;
	endfunction

	function automatic midi_request_t raw_item(logic [7:0] data, logic fin);
		midi_request_t r;
		r       = channel_message(3'($urandom), 5'($urandom), data, 8'($urandom),
			15'($urandom));
		r.req   = REQ_RAW;
		r.fin   = fin;
		return r;
	endfunction

	function automatic midi_request_t read_item(logic [6:0] limit);
		midi_request_t r;
		r       = raw_item(8'($urandom), 1'($urandom));
		r.req   = REQ_READ;
		r.limit = limit;
		return r;
	endfunction

	// well-formed message with random content
	function automatic midi_request_t tidy_message();
		logic [2:0] kind;
		kind = 3'($urandom_range(6));
		return channel_message(kind, 5'($urandom_range(16, 1)), 8'($urandom_range(127)),
			(kind == KIND_PGMCHG || kind == KIND_TOUCH) ? 8'($urandom)
				: 8'($urandom_range(127)),
			15'($urandom_range(16383)));
	endfunction

	// every field across its whole width, so most of these are refused
	function automatic midi_request_t noise_message();
		return channel_message(3'($urandom), 5'($urandom), 8'($urandom), 8'($urandom),
			15'($urandom));
	endfunction

	// ---- drivers ----

	// Offer one word and hold it until taken. Valid stays high on return, so a
	// back-to-back word never lowers and raises it in the same step.
	task automatic send_request(input midi_request_t r);
		if (sender_idles && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		req_type        <= r.req;
		msg_kind        <= r.kind;
		channel         <= r.chan;
		first_data      <= r.d1;
		second_data     <= r.d2;
		bend_value      <= r.bend;
		last_of_message <= r.fin;
		read_limit      <= r.limit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.take_request(r);
	endtask

	// drop valid, wait out every owed word, then let the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_words() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// write both registers on consecutive edges while the block is idle
	task automatic configure(input logic enable, input logic dsp);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_QUEUE_ENABLED;
		cfg_data  <= enable;
		@(posedge clk);
		sb.write_register(CFG_QUEUE_ENABLED, enable);
		cfg_index <= CFG_DSP_RUNNING;
		cfg_data  <= dsp;
		@(posedge clk);
		sb.write_register(CFG_DSP_RUNNING, dsp);
		cfg_we    <= 1'b0;
	endtask

	// Mostly well-formed messages, raw lists and reads; the rest is noise, lists
	// cut short by another request, and unused request codes (not counted).
	task automatic run_traffic(input int unsigned items);
		int unsigned counted;
		int unsigned pick;
		int unsigned len;
		midi_request_t r;
		counted = 0;
		while (counted < items) begin
			pick = $urandom_range(99);
			if (pick < 38) begin
				send_request(tidy_message());
				counted++;
			end else if (pick < 58) begin
				len = $urandom_range(6, 1);
				for (int unsigned k = 0; k < len; k++)
					send_request(raw_item(8'($urandom), k == len - 1));
				counted += len;
			end else if (pick < 80) begin
				send_request(read_item(($urandom_range(9) == 0) ? 7'($urandom)
					: 7'($urandom_range(64, 1))));
				counted++;
			end else if (pick < 90) begin
				send_request(noise_message());
				counted++;
			end else if (pick < 96) begin
				// something cuts into an open list; the list may stay open afterwards
				send_request(raw_item(8'($urandom), 1'b0));
				send_request($urandom_range(1) ? tidy_message()
					: read_item(7'($urandom_range(64))));
				send_request(raw_item(8'($urandom), 1'($urandom)));
				counted += 3;
			end else begin
				r     = read_item(7'($urandom));
				r.req = REQ_UNUSED;
				send_request(r);
			end
		end
	endtask

	// ---- result side: check each accepted word, idle at random, stall on request ----

	initial begin : result_sink
		int unsigned hold_left;
		queue_word_t seen;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen = {out_byte, byte_valid, last, status};
				sb.check_word(seen);
			end
			if (hold_requested) begin
				hold_requested = 1'b0;
				hold_left      = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(receiver_idles && $urandom_range(99) < 14);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---- stimulus ----

	initial begin : stimulus
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		req_type        <= REQ_MSG;
		msg_kind        <= KIND_NOTEON;
		channel         <= 5'd1;
		first_data      <= 8'h00;
		second_data     <= 8'h00;
		bend_value      <= 15'h0000;
		last_of_message <= 1'b0;
		read_limit      <= 7'd0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_QUEUE_ENABLED;
		cfg_data        <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the input is closed: everything reports disabled,
		// including a raw list that latches the error and drops on its last byte.
		send_request(channel_message(KIND_NOTEON, 5'd1, 8'd60, 8'd100, 15'd0));
		send_request(raw_item(8'hf0, 1'b0));
		send_request(raw_item(8'hf7, 1'b1));
		send_request(read_item(7'd10));

		// input open but processing off: writes refused, reads still served
		configure(1'b1, 1'b0);
		send_request(channel_message(KIND_CTLCHG, 5'd3, 8'd7, 8'd64, 15'd0));
		send_request(raw_item(8'h90, 1'b1));
		send_request(read_item(7'd0));

		// every message kind at the edges of its fields, then each refusal
		configure(1'b1, 1'b1);
		send_request(channel_message(KIND_NOTEON, 5'd1, 8'd0, 8'd0, 15'd0));
		send_request(channel_message(KIND_NOTEOFF, 5'd16, 8'd127, 8'd127, 15'h7fff));
		send_request(channel_message(KIND_CTLCHG, 5'd5, 8'd7, 8'd100, 15'd0));
		send_request(channel_message(KIND_PGMCHG, 5'd2, 8'd127, 8'd255, 15'd0));
		send_request(channel_message(KIND_POLYTOUCH, 5'd9, 8'd60, 8'd127, 15'd0));
		send_request(channel_message(KIND_TOUCH, 5'd16, 8'd0, 8'd200, 15'd0));
		send_request(channel_message(KIND_BEND, 5'd1, 8'd255, 8'd255, 15'd0));
		send_request(channel_message(KIND_BEND, 5'd16, 8'd0, 8'd0, 15'd16383));
		send_request(channel_message(KIND_BEND, 5'd3, 8'd0, 8'd0, 15'd16384));
		send_request(channel_message(KIND_NOTEON, 5'd0, 8'd60, 8'd100, 15'd0));
		send_request(channel_message(KIND_BEND, 5'd17, 8'd0, 8'd0, 15'd8192));
		send_request(channel_message(KIND_NOTEON, 5'd31, 8'd255, 8'd255, 15'h7fff));
		send_request(channel_message(KIND_NOTEON, 5'd4, 8'd128, 8'd10, 15'd0));
		send_request(channel_message(KIND_CTLCHG, 5'd4, 8'd10, 8'd255, 15'd0));
		send_request(channel_message(3'd7, 5'd4, 8'd10, 8'd10, 15'd0));
		// a complete raw list commits as one
		send_request(raw_item(8'hf0, 1'b0));
		send_request(raw_item(8'h7e, 1'b0));
		send_request(raw_item(8'hf7, 1'b1));
		// a message inside an open list is refused and leaves the list alone
		send_request(raw_item(8'h11, 1'b0));
		send_request(channel_message(KIND_NOTEON, 5'd1, 8'd1, 8'd1, 15'd0));
		send_request(raw_item(8'h22, 1'b1));
		// empty read, an oversized limit that caps at the maximum, a read on empty, then an unused code
		send_request(read_item(7'd0));
		send_request(read_item(7'd127));
		send_request(read_item(7'd5));
		send_request(read_item(7'd0) ^ {REQ_UNUSED ^ REQ_READ, 47'd0});

		run_traffic(70);

		// rewriting an open input must keep the queue; then a stretch with no idling
		configure(1'b1, 1'b1);
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		run_traffic(50);
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;

		// input closed, then reopened, which empties the queue
		configure(1'b0, 1'b1);
		run_traffic(30);
		configure(1'b1, 1'b1);
		run_traffic(60);

		// processing off with the input open
		configure(1'b1, 1'b0);
		run_traffic(30);

		// Fill the queue to capacity, hit the full refusals, then drain it while
		// the receiver holds off so the block backs up and stalls its input.
		configure(1'b1, 1'b1);
		send_request(raw_item(8'($urandom), 1'b1));
		while (sb.free_space() >= 3) send_request(tidy_message());
		send_request(channel_message(KIND_NOTEON, 5'd1, 8'd60, 8'd100, 15'd0));
		while (sb.free_space() > 0) send_request(raw_item(8'($urandom), 1'b1));
		send_request(raw_item(8'h55, 1'b0));
		send_request(raw_item(8'haa, 1'b1));
		send_request(channel_message(KIND_PGMCHG, 5'd8, 8'd5, 8'd0, 15'd0));
		hold_requested = 1'b1;
		while (sb.queued_bytes() > 0) send_request(read_item(7'd64));
		send_request(read_item(7'd64));

		settle();
		if (sb.failures == 0 && sb.pending_words() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
